FILE: rtl/bsm_pkg.sv
// Shared widths, codes and beat types for the bounding sphere merge block.
`timescale 1ns / 1ps
`default_nettype none

package bsm_pkg;

    // Coordinate width and the widths that follow from it
    localparam int CW     = 32;          // signed Q16.16 center
    localparam int RW     = CW - 1;      // unsigned radius
    localparam int XW     = CW + 1;      // box corner, center plus or minus radius
    localparam int SQW    = 2 * RW;      // squared distance below the clamp limit
    localparam int QDEPTH = 2;           // finish snapshots waiting for the back end

    // Action codes
    localparam logic ACT_ADD    = 1'b0;
    localparam logic ACT_FINISH = 1'b1;

    // Sphere count, saturating at "two or more"
    typedef logic [1:0] t_count;
    localparam t_count CNT_NONE = 2'd0;
    localparam t_count CNT_ONE  = 2'd1;
    localparam t_count CNT_MANY = 2'd2;

    typedef logic signed [XW-1:0] t_corner;

    // Empty box: low corner at the top of its range, high corner at the bottom
    localparam t_corner LOW_INIT  = {1'b0, {CW{1'b1}}};
    localparam t_corner HIGH_INIT = {1'b1, {CW{1'b0}}};

    // Input beat
    typedef struct packed {
        logic                 action;
        logic signed [CW-1:0] center_x;
        logic signed [CW-1:0] center_y;
        logic signed [CW-1:0] center_z;
        logic        [RW-1:0] sphere_radius;
    } t_in;

    // Result beat
    typedef struct packed {
        logic signed [CW-1:0] merged_x;
        logic signed [CW-1:0] merged_y;
        logic signed [CW-1:0] merged_z;
        logic        [RW-1:0] merged_radius;
        logic                 saturated;
    } t_out;

    // Accumulated state handed from the front end to the back end on finish
    typedef struct packed {
        t_count               count;
        logic signed [CW-1:0] first_x;
        logic signed [CW-1:0] first_y;
        logic signed [CW-1:0] first_z;
        logic        [RW-1:0] first_r;
        t_corner [2:0]        low;
        t_corner [2:0]        high;
    } t_snap;

endpackage

`default_nettype wire

FILE: rtl/bsm_front.sv
// Front end: accepts beats, tracks the sphere count and the box, snapshots on finish.
`timescale 1ns / 1ps
`default_nettype none

module bsm_front
    import bsm_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_accept,
    input  wire t_in   i_item,
    output logic       o_push,
    output t_snap      o_snap
);

    t_count               r_cnt;
    logic signed [CW-1:0] r_first [3];
    logic        [RW-1:0] r_first_r;
    t_corner              r_low   [3];
    t_corner              r_high  [3];

    t_corner w_c  [3];
    t_corner w_r;
    t_corner w_lo [3];
    t_corner w_hi [3];

    // Extend the center and radius and form the sphere's extent per axis
    always_comb begin
        w_r    = {2'b00, i_item.sphere_radius};
        w_c[0] = {i_item.center_x[CW-1], i_item.center_x};
        w_c[1] = {i_item.center_y[CW-1], i_item.center_y};
        w_c[2] = {i_item.center_z[CW-1], i_item.center_z};
        for (int i = 0; i < 3; i++) begin
            w_lo[i] = w_c[i] - w_r;
            w_hi[i] = w_c[i] + w_r;
        end
    end

    // Hand the current state to the queue on a finish beat
    assign o_push = i_accept && (i_item.action == ACT_FINISH);

    always_comb begin
        o_snap.count   = r_cnt;
        o_snap.first_x = r_first[0];
        o_snap.first_y = r_first[1];
        o_snap.first_z = r_first[2];
        o_snap.first_r = r_first_r;
        for (int i = 0; i < 3; i++) begin
            o_snap.low[i]  = r_low[i];
            o_snap.high[i] = r_high[i];
        end
    end

    // Count and box: widen on add, clear on finish
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= CNT_NONE;
            for (int i = 0; i < 3; i++) begin
                r_low[i]  <= LOW_INIT;
                r_high[i] <= HIGH_INIT;
            end
        end else if (i_accept) begin
            if (i_item.action == ACT_ADD) begin
                for (int i = 0; i < 3; i++) begin
                    if (w_lo[i] < r_low[i])  r_low[i]  <= w_lo[i];
                    if (w_hi[i] > r_high[i]) r_high[i] <= w_hi[i];
                end
                if (r_cnt != CNT_MANY) r_cnt <= r_cnt + t_count'(1);
            end else begin
                r_cnt <= CNT_NONE;
                for (int i = 0; i < 3; i++) begin
                    r_low[i]  <= LOW_INIT;
                    r_high[i] <= HIGH_INIT;
                end
            end
        end
    end

    // Keep the first sphere for the single-sphere case
    always_ff @(posedge i_clk) begin
        if (i_accept && (i_item.action == ACT_ADD) && (r_cnt == CNT_NONE)) begin
            r_first[0] <= i_item.center_x;
            r_first[1] <= i_item.center_y;
            r_first[2] <= i_item.center_z;
            r_first_r  <= i_item.sphere_radius;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/bsm_fifo.sv
// Short queue of finish snapshots between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none

module bsm_fifo
    import bsm_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_snap i_data,
    input  wire logic  i_pop,
    output t_snap      o_data,
    output logic       o_full,
    output logic       o_valid
);

    localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int LW = $clog2(QDEPTH + 1);

    t_snap           r_mem [QDEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [LW-1:0]   r_level;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
        return (p == AW'(QDEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    assign o_full  = (r_level == LW'(QDEPTH));
    assign o_valid = (r_level != '0);
    assign o_data  = r_mem[r_rd];

    // Advance pointers and level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            if (i_push) r_wr <= wrap_inc(r_wr);
            if (i_pop)  r_rd <= wrap_inc(r_rd);
            if (i_push && !i_pop)      r_level <= r_level + LW'(1);
            else if (!i_push && i_pop) r_level <= r_level - LW'(1);
        end
    end

    // Store the snapshot
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_data;
    end

endmodule

`default_nettype wire

FILE: rtl/bsm_back.sv
// Back end: midpoint, squared distance, bit-serial square root and result register.
`timescale 1ns / 1ps
`default_nettype none

module bsm_back
    import bsm_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_q_valid,
    input  wire t_snap i_head,
    output logic       o_take,
    output logic       o_busy,
    input  wire logic  i_pop,
    output logic       o_empty,
    output t_out       o_result
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_MID   = 7'b0000010,
        ST_MUL   = 7'b0000100,
        ST_ACC   = 7'b0001000,
        ST_CHECK = 7'b0010000,
        ST_ROOT  = 7'b0100000,
        ST_DONE  = 7'b1000000
    } t_state;

    t_state             r_state, n_state;
    t_snap              r_snap,  n_snap;
    logic [RW-1:0]      r_d [3];
    logic [RW-1:0]      n_d [3];
    logic               r_big,   n_big;
    t_out               r_res,   n_res;
    logic [1:0]         r_k,     n_k;
    logic [SQW-1:0]     r_prod,  n_prod;
    logic [SQW+1:0]     r_sum,   n_sum;
    logic [SQW-1:0]     r_rem,   n_rem;
    logic [SQW-1:0]     r_root,  n_root;
    logic [SQW-1:0]     r_bit,   n_bit;
    t_out               r_out,   n_out;
    logic               r_out_valid, n_out_valid;

    logic signed [XW:0]   w_sum  [3];
    logic signed [XW-1:0] w_mid  [3];
    logic        [XW:0]   w_dist [3];
    logic signed [CW-1:0] w_ctr  [3];
    logic                 w_clip [3];
    logic                 w_far  [3];
    logic [SQW-1:0]       w_trial;
    logic [SQW-1:0]       w_root_next;

    // Midpoint, distance to the low corner and center clamp per axis
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_sum[i]  = $signed({r_snap.low[i][XW-1], r_snap.low[i]})
                      + $signed({r_snap.high[i][XW-1], r_snap.high[i]});
            w_mid[i]  = w_sum[i][XW:1];
            w_dist[i] = {w_mid[i][XW-1], w_mid[i]} - {r_snap.low[i][XW-1], r_snap.low[i]};
            w_far[i]  = |w_dist[i][XW:RW];
            w_clip[i] = (w_mid[i][XW-1] != w_mid[i][CW-1]);
            if (w_clip[i]) begin
                w_ctr[i] = w_mid[i][XW-1] ? {1'b1, {RW{1'b0}}} : {1'b0, {RW{1'b1}}};
            end else begin
                w_ctr[i] = w_mid[i][CW-1:0];
            end
        end
    end

    // One restoring square root step
    always_comb begin
        w_trial = r_root + r_bit;
        if (r_rem >= w_trial) begin
            w_root_next = (r_root >> 1) + r_bit;
        end else begin
            w_root_next = r_root >> 1;
        end
    end

    assign o_busy   = (r_state != ST_IDLE);
    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

    // Sequence one finish snapshot to a result
    always_comb begin
        n_state     = r_state;
        n_snap      = r_snap;
        n_d         = r_d;
        n_big       = r_big;
        n_res       = r_res;
        n_k         = r_k;
        n_prod      = r_prod;
        n_sum       = r_sum;
        n_rem       = r_rem;
        n_root      = r_root;
        n_bit       = r_bit;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_pop;
        o_take      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_take = 1'b1;
                    n_snap = i_head;
                    case (i_head.count)
                        CNT_NONE: begin
                            n_res   = '0;
                            n_state = ST_DONE;
                        end
                        CNT_ONE: begin
                            n_res.merged_x      = i_head.first_x;
                            n_res.merged_y      = i_head.first_y;
                            n_res.merged_z      = i_head.first_z;
                            n_res.merged_radius = i_head.first_r;
                            n_res.saturated     = 1'b0;
                            n_state             = ST_DONE;
                        end
                        default: begin
                            n_state = ST_MID;
                        end
                    endcase
                end
            end
            ST_MID: begin
                for (int i = 0; i < 3; i++) n_d[i] = w_dist[i][RW-1:0];
                n_big           = w_far[0] || w_far[1] || w_far[2];
                n_res.merged_x  = w_ctr[0];
                n_res.merged_y  = w_ctr[1];
                n_res.merged_z  = w_ctr[2];
                n_res.saturated = w_clip[0] || w_clip[1] || w_clip[2];
                n_k             = '0;
                n_sum           = '0;
                n_state         = ST_MUL;
            end
            ST_MUL: begin
                n_prod  = r_d[r_k] * r_d[r_k];
                n_state = ST_ACC;
            end
            ST_ACC: begin
                n_sum = r_sum + {2'b00, r_prod};
                if (r_k == 2'd2) begin
                    n_state = ST_CHECK;
                end else begin
                    n_k     = r_k + 2'd1;
                    n_state = ST_MUL;
                end
            end
            ST_CHECK: begin
                if (r_big || (|r_sum[SQW+1:SQW])) begin
                    n_res.merged_radius = {RW{1'b1}};
                    n_res.saturated     = 1'b1;
                    n_state             = ST_DONE;
                end else begin
                    n_rem   = r_sum[SQW-1:0];
                    n_root  = '0;
                    n_bit   = {2'b01, {(SQW-2){1'b0}}};
                    n_state = ST_ROOT;
                end
            end
            ST_ROOT: begin
                if (r_rem >= w_trial) n_rem = r_rem - w_trial;
                n_root = w_root_next;
                n_bit  = r_bit >> 2;
                if (r_bit[0]) begin
                    n_res.merged_radius = w_root_next[RW-1:0];
                    n_state             = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_pop) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_snap <= n_snap;
        r_d    <= n_d;
        r_big  <= n_big;
        r_res  <= n_res;
        r_k    <= n_k;
        r_prod <= n_prod;
        r_sum  <= n_sum;
        r_rem  <= n_rem;
        r_root <= n_root;
        r_bit  <= n_bit;
        r_out  <= n_out;
    end

endmodule

`default_nettype wire

FILE: rtl/bounding_sphere_merge_top.sv
// Top level of the bounding sphere merge block: front end, snapshot queue, back end.
// Add beats are taken one per cycle; they stall only while the snapshot queue is full.
// A finish with two or more spheres is worked in the back end with three multiplies on one
// multiplier and CW-1 root steps; the back end takes the next snapshot only once it is idle.
// A finish with zero or one sphere skips the arithmetic and goes from idle straight to done.
// Synchronous active-low reset clears the box, the count, the queue and the result valid flag.
`timescale 1ns / 1ps
`default_nettype none

module bounding_sphere_merge_top
    import bsm_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic push,
    output logic      full,
    input  wire t_in  i_item,
    output logic      empty,
    input  wire logic pop,
    output t_out      o_result
);

    logic  w_accept;
    logic  w_fin_push;
    t_snap w_snap;
    t_snap w_head;
    logic  w_q_full;
    logic  w_q_valid;
    logic  w_take;
    logic  w_busy;

    assign full     = w_q_full;
    assign w_accept = push && !w_q_full;

    bsm_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_item   (i_item),
        .o_push   (w_fin_push),
        .o_snap   (w_snap)
    );

    bsm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fin_push),
        .i_data  (w_snap),
        .i_pop   (w_take),
        .o_data  (w_head),
        .o_full  (w_q_full),
        .o_valid (w_q_valid)
    );

    bsm_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_head    (w_head),
        .o_take    (w_take),
        .o_busy    (w_busy),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (o_result)
    );

    // Back end takes a snapshot only from idle, and is busy right after
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |-> (!w_busy ##1 w_busy))
        else $error("snapshot taken while back end busy");

    // Back end never takes from an empty queue
    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |-> w_q_valid)
        else $error("snapshot taken from empty queue");

    // A finish beat into an empty queue is waiting there next cycle
    a_fin_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_item.action == ACT_FINISH) && !w_q_valid) |=> w_q_valid)
        else $error("finish beat lost before queue");

endmodule

`default_nettype wire

FILE: verif/tb_bounding_sphere_merge_top.sv
// Self-checking testbench for the bounding sphere merge block, queue handshakes on both sides.
`timescale 1ns / 1ps

module tb_bounding_sphere_merge_top;
    import bsm_pkg::*;

    localparam int STALL_LIMIT  = 4000;       // cycles with no beat on either side
    localparam int DRAIN_CYCLES = CW + 40;    // covers the square root latency
    localparam int TOTAL_ITEMS  = 1250;
    localparam int BURST_ITEMS  = 300;        // beats sent with no idling at all

    localparam logic [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [RW-1:0] R_MAX = {RW{1'b1}};

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic push    = 1'b0;
    logic pop     = 1'b0;
    t_in  i_item  = '0;
    logic full;
    logic empty;
    t_out o_result;

    // Running box state of the predictor
    t_count              sph_count;
    logic signed [CW-1:0] first_ctr [3];
    logic        [RW-1:0] first_rad;
    t_corner              box_lo [3];
    t_corner              box_hi [3];

    t_out merged_q [$];
    bit   idle_on    = 1'b1;
    int   fail_count = 0;
    int   beats_sent = 0;
    int   spheres_checked = 0;
    int   n_empty = 0;
    int   n_single = 0;
    int   n_sat = 0;
    int   quiet_cycles = 0;

    bounding_sphere_merge_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Empty the box: low corner at the top of its range, high at the bottom
    task automatic clear_box();
        sph_count = CNT_NONE;
        first_rad = '0;
        for (int i = 0; i < 3; i++) begin
            first_ctr[i] = '0;
            box_lo[i]    = LOW_INIT;
            box_hi[i]    = HIGH_INIT;
        end
    endtask

    // Enclosing sphere of the current box, two or more spheres seen
    function automatic t_out enclose_box();
        t_out                  res;
        logic signed [XW:0]    pair_sum;
        logic signed [XW:0]    mid;
        logic signed [XW+1:0]  span;
        logic signed [CW-1:0]  ctr [3];
        logic        [65:0]    sq_sum;
        logic        [65:0]    d66;
        logic        [65:0]    cand66;
        logic        [RW-1:0]  root;
        logic        [RW-1:0]  cand;
        logic                  big;
        logic                  sat;
        sq_sum = '0;
        big    = 1'b0;
        sat    = 1'b0;
        for (int i = 0; i < 3; i++) begin
            pair_sum = box_lo[i] + box_hi[i];
            mid      = pair_sum >>> 1;
            span     = mid - box_lo[i];
            // Clamp a midpoint that leaves the signed coordinate range
            if (mid[XW:CW-1] != {(XW-CW+2){mid[XW]}}) begin
                sat    = 1'b1;
                ctr[i] = mid[XW] ? C_MIN : C_MAX;
            end else begin
                ctr[i] = mid[CW-1:0];
            end
            if (|span[XW+1:RW]) begin
                big = 1'b1;
            end else begin
                d66    = 66'(span[RW-1:0]);
                sq_sum = sq_sum + d66 * d66;
            end
        end
        root = '0;
        if (big || sq_sum >= (66'd1 << (2 * CW - 2))) begin
            root = R_MAX;
            sat  = 1'b1;
        end else begin
            // Floor square root, one bit at a time from the top
            for (int b = RW - 1; b >= 0; b--) begin
                cand   = root | (RW'(1) << b);
                cand66 = 66'(cand);
                if (cand66 * cand66 <= sq_sum) root = cand;
            end
        end
        res.merged_x      = ctr[0];
        res.merged_y      = ctr[1];
        res.merged_z      = ctr[2];
        res.merged_radius = root;
        res.saturated     = sat;
        return res;
    endfunction

    // Advance the predictor by one accepted beat
    task automatic absorb_beat(input t_in b);
        logic signed [CW-1:0] ctr [3];
        t_corner              c_s;
        t_corner              r_s;
        t_out                 res;
        if (b.action == ACT_ADD) begin
            ctr[0] = b.center_x;
            ctr[1] = b.center_y;
            ctr[2] = b.center_z;
            r_s    = $signed({2'b00, b.sphere_radius});
            for (int i = 0; i < 3; i++) begin
                c_s = t_corner'(ctr[i]);
                if (c_s - r_s < box_lo[i]) box_lo[i] = c_s - r_s;
                if (c_s + r_s > box_hi[i]) box_hi[i] = c_s + r_s;
                if (sph_count == CNT_NONE) first_ctr[i] = ctr[i];
            end
            if (sph_count == CNT_NONE) first_rad = b.sphere_radius;
            if (sph_count != CNT_MANY) sph_count = sph_count + t_count'(1);
        end else begin
            if (sph_count == CNT_NONE) begin
                res = '0;
                n_empty++;
            end else if (sph_count == CNT_ONE) begin
                res.merged_x      = first_ctr[0];
                res.merged_y      = first_ctr[1];
                res.merged_z      = first_ctr[2];
                res.merged_radius = first_rad;
                res.saturated     = 1'b0;
                n_single++;
            end else begin
                res = enclose_box();
                if (res.saturated) n_sat++;
            end
            merged_q.push_back(res);
            clear_box();
        end
    endtask

    // Drive one beat, with an occasional idle gap ahead of it
    task automatic send_item(input t_in b);
        @(negedge i_clk);
        if (idle_on && $urandom_range(99) < 30) begin
            push   <= 1'b0;
            i_item <= {$urandom, $urandom, $urandom, $urandom};
            repeat ($urandom_range(1, 2)) @(negedge i_clk);
        end
        push   <= 1'b1;
        i_item <= b;
        do @(posedge i_clk); while (full);
        absorb_beat(b);
        beats_sent++;
    endtask

    function automatic t_in make_add(logic [CW-1:0] x, logic [CW-1:0] y,
                                     logic [CW-1:0] z, logic [RW-1:0] r);
        t_in b;
        b.action        = ACT_ADD;
        b.center_x      = x;
        b.center_y      = y;
        b.center_z      = z;
        b.sphere_radius = r;
        return b;
    endfunction

    // Finish beat with junk in the ignored fields
    function automatic t_in make_finish();
        t_in b;
        b        = make_add($urandom, $urandom, $urandom, RW'($urandom));
        b.action = ACT_FINISH;
        return b;
    endfunction

    function automatic logic [CW-1:0] pick_coord(logic [CW-1:0] base);
        case ($urandom_range(9))
            0, 1: return $urandom;
            2: begin
                case ($urandom_range(3))
                    0:       return C_MIN;
                    1:       return C_MAX;
                    2:       return '0;
                    default: return '1;
                endcase
            end
            default: return base + CW'($urandom_range(0, 2**20)) - CW'(2**19);
        endcase
    endfunction

    function automatic logic [RW-1:0] pick_radius();
        case ($urandom_range(9))
            0:       return RW'($urandom);
            1:       return ($urandom_range(1) != 0) ? R_MAX : '0;
            default: return RW'($urandom_range(0, 2**22));
        endcase
    endfunction

    // Adds around a common base, then one finish
    task automatic run_sequence();
        int            k;
        int            n_adds;
        logic [CW-1:0] base;
        k      = $urandom_range(99);
        n_adds = (k < 8) ? 0 : (k < 20) ? 1 :
                 (k < 85) ? $urandom_range(2, 6) : $urandom_range(7, 20);
        base   = $urandom;
        if ($urandom_range(3) == 0) base = $signed(base) >>> 12;
        for (int i = 0; i < n_adds; i++) begin
            send_item(make_add(pick_coord(base), pick_coord(base), pick_coord(base),
                               pick_radius()));
        end
        send_item(make_finish());
    endtask

    // Empty finish, single sphere passed through, ignored fields on finish
    task automatic test_empty_and_single();
        send_item(make_finish());
        send_item(make_add(C_MIN, C_MAX, '0, R_MAX));
        send_item(make_finish());
        send_item(make_add(C_MAX, '1, C_MIN, '0));
        send_item(make_finish());
        send_item(make_finish());
    endtask

    // Midpoint rounding, radius saturation by range and by size, zero radii
    task automatic test_box_merge();
        send_item(make_add(32'd1, -32'sd1, 32'd5, '0));
        send_item(make_add(32'd2, -32'sd2, 32'd4, '0));
        send_item(make_finish());
        send_item(make_add(C_MIN, C_MIN, C_MIN, R_MAX));
        send_item(make_add(C_MAX, C_MAX, C_MAX, R_MAX));
        send_item(make_finish());
        send_item(make_add('0, '0, '0, RW'(32'h6000_0000)));
        send_item(make_add('0, '0, '0, RW'(32'h6000_0000)));
        send_item(make_finish());
        send_item(make_add('0, '0, '0, RW'(32'h4000_0000)));
        send_item(make_add('0, '0, '0, RW'(32'h4000_0000)));
        send_item(make_finish());
        send_item(make_add(-32'sd7, 32'd3, 32'h0001_0000, '0));
        send_item(make_add(32'd8, -32'sd9, 32'h0002_0000, '0));
        send_item(make_add(32'd0, 32'd0, -32'sh0001_0000, '0));
        send_item(make_finish());
    endtask

    // Random sequences with both sides idling
    task automatic test_random_traffic(input int stop_at);
        idle_on = 1'b1;
        while (beats_sent < stop_at) run_sequence();
    endtask

    // Random sequences at full rate on both sides
    task automatic test_full_rate(input int stop_at);
        idle_on = 1'b0;
        while (beats_sent < stop_at) run_sequence();
        idle_on = 1'b1;
    endtask

    // Drain side: pop with random stalls
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            pop <= !idle_on || ($urandom_range(99) >= 30);
        end
    end

    task automatic check_field(input string field, input logic [CW-1:0] want_v,
                               input logic [CW-1:0] got_v);
        if (want_v !== got_v) begin
            $error("%s: expected %h, got %h", field, want_v, got_v);
            fail_count++;
        end
    endtask

    // Compare each popped beat with the oldest expected sphere
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && pop && !empty) begin
            if (merged_q.size() == 0) begin
                $error("merged sphere with none expected: %h", o_result);
                fail_count++;
            end else begin
                want = merged_q.pop_front();
                check_field("merged_x", want.merged_x, o_result.merged_x);
                check_field("merged_y", want.merged_y, o_result.merged_y);
                check_field("merged_z", want.merged_z, o_result.merged_z);
                check_field("merged_radius", CW'(want.merged_radius),
                            CW'(o_result.merged_radius));
                check_field("saturated", CW'(want.saturated), CW'(o_result.saturated));
                spheres_checked++;
            end
        end
    end

    // Watchdog: end the run if neither side moves a beat for too long
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: no beat for %0d cycles", STALL_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        clear_box();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_and_single();
        test_box_merge();
        test_random_traffic(TOTAL_ITEMS / 2);
        test_full_rate(TOTAL_ITEMS / 2 + BURST_ITEMS);
        test_random_traffic(TOTAL_ITEMS);

        @(negedge i_clk);
        push <= 1'b0;
        while (merged_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d input beats and %0d merged spheres", beats_sent,
                 spheres_checked);
        $display("  (%0d with no sphere, %0d single, %0d saturated)", n_empty, n_single,
                 n_sat);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: bounding_sphere_merge_top.f
rtl/bsm_pkg.sv
rtl/bsm_front.sv
rtl/bsm_fifo.sv
rtl/bsm_back.sv
rtl/bounding_sphere_merge_top.sv
verif/tb_bounding_sphere_merge_top.sv
